// ----- design/price_level_order_book_defines.svh -----
// ----------------------------------------------------------------------------
// Price level order book assertion macros
// Concurrent check macros; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`ifndef SYNTHESIS
`define PLOB_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("order book check failed");
`define PLOB_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("order book sequence check failed");
`else
`define PLOB_ALWAYS(label, expr)
`define PLOB_NEXT(label, ante, cons)
`endif
`endif

// ----- design/plob_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book package
// Command and status codes and fixed field widths.
// ----------------------------------------------------------------------------
package plob_pkg;
  localparam int ID_W  = 32;
  localparam int QTY_W = 32;
  localparam int PX_W  = 32;
  localparam int SUM_W = 42;

  typedef logic [2:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_ADD     = 3'd0;
  localparam cmd_t CMD_CANCEL  = 3'd1;
  localparam cmd_t CMD_REDUCE  = 3'd2;
  localparam cmd_t CMD_EXECUTE = 3'd3;
  localparam cmd_t CMD_REPLACE = 3'd4;
  localparam cmd_t CMD_QUERY   = 3'd5;
  localparam cmd_t CMD_SPARE_A = 3'd6;
  localparam cmd_t CMD_SPARE_B = 3'd7;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BAD_QTY  = 3'd1;
  localparam status_t ST_WINDOW   = 3'd2;
  localparam status_t ST_DUP      = 3'd3;
  localparam status_t ST_FULL     = 3'd4;
  localparam status_t ST_UNKNOWN  = 3'd5;
  localparam status_t ST_EXCEEDS  = 3'd6;
  localparam status_t ST_NEW_LIVE = 3'd7;
endpackage

// ----- design/plob_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module plob_ram
  import plob_pkg::*;
#(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- design/price_level_order_book.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book
// Market-by-order book over a window of LEVELS price ticks.
// ----------------------------------------------------------------------------
// After reset the block clears every level entry and every order key and
// accepts no beat meanwhile.
// One beat is processed at a time: a command that needs the order table scans
// every entry, one per cycle; a removal that empties the best level while
// other levels stay occupied rescans the level memory through its read port.
// A query or a rejected quantity skips the scan.
// A finished result waits in the output register while the next beat is taken.
`include "price_level_order_book_defines.svh"
module price_level_order_book
  import plob_pkg::*;
#(
  parameter int LEVELS = 1024,
  parameter int ORDERS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd
  input  logic [2:0]   in_tuser,
  // order_id, new_order_id, is_sell, price_ticks, quantity, zero fill
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, bid_valid, best_bid_price, ask_valid, best_ask_price,
  // level_quantity, zero fill
  output logic [111:0] out_tdata
);
  localparam int LW     = $clog2(LEVELS);
  localparam int LCW    = $clog2(LEVELS + 1);
  localparam int LAW    = LW + 1;
  localparam int LDEPTH = 2 * (2 ** LW);
  localparam int OW     = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int OCW    = $clog2(ORDERS + 1);
  localparam int CLR_N  = (LDEPTH > ORDERS) ? LDEPTH : ORDERS;
  localparam int CLRW   = $clog2(CLR_N + 1);
  localparam int EW     = 1 + QTY_W + LW;
  localparam int KW     = 1 + ID_W;
  localparam int HALF   = LEVELS / 2;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_SDRN = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_ENT  = 4'd6;
  localparam logic [3:0] S_LRD  = 4'd7;
  localparam logic [3:0] S_LUPD = 4'd8;
  localparam logic [3:0] S_RSC  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CLRW-1:0]  clr_r, clr_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt, nid_r, nid_nxt;
  logic             sell_r, sell_nxt;
  logic [PX_W-1:0]  price_r, price_nxt;
  logic [QTY_W-1:0] qty_r, qty_nxt;
  logic             anch_r, anch_nxt;
  logic [32:0]      base_r, base_nxt;
  logic [OCW-1:0]   live_r, live_nxt;
  logic [LCW-1:0]   bcnt_r, bcnt_nxt, acnt_r, acnt_nxt;
  logic [LW-1:0]    bbest_r, bbest_nxt, abest_r, abest_nxt;
  logic [OW-1:0]    scan_r, scan_nxt, spidx_r, spidx_nxt;
  logic             spend_r, spend_nxt;
  logic             hit_r, hit_nxt, nhit_r, nhit_nxt, free_r, free_nxt;
  logic [OW-1:0]    hidx_r, hidx_nxt, fidx_r, fidx_nxt;
  status_t          status_r, status_nxt;
  logic             lside_r, lside_nxt, lsub_r, lsub_nxt;
  logic             addp_r, addp_nxt, aside_r, aside_nxt;
  logic [LW-1:0]    lidx_r, lidx_nxt;
  logic [QTY_W-1:0] lamt_r, lamt_nxt;
  logic [LW-1:0]    rs_r, rs_nxt, rs_pidx_r, rs_pidx_nxt;
  logic             rs_more_r, rs_more_nxt, rs_pend_r, rs_pend_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [111:0]     out_data_r, out_data_nxt;

  logic             key_we, ent_we, lvl_we;
  logic [OW-1:0]    key_waddr, ent_waddr;
  logic [KW-1:0]    key_wdata, key_rdata;
  logic [EW-1:0]    ent_wdata, ent_rdata;
  logic [LAW-1:0]   lvl_waddr, lvl_raddr;
  logic [SUM_W-1:0] lvl_wdata, lvl_rdata;

  logic [33:0]      woff;
  logic             win_ok;
  logic [LW-1:0]    win_idx;
  logic             e_sell;
  logic [QTY_W-1:0] e_qty, e_newq;
  logic [LW-1:0]    e_idx;
  logic [SUM_W-1:0] nsum;
  logic [LCW-1:0]   cnt_dec;
  logic [32:0]      bsum, asum;
  logic             kv;

  plob_ram #(.DW(KW), .AW(OW)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(scan_r), .rdata(key_rdata)
  );
  plob_ram #(.DW(EW), .AW(OW)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(hidx_r), .rdata(ent_rdata)
  );
  plob_ram #(.DW(SUM_W), .AW(LAW)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  assign woff    = {{2{price_r[31]}}, price_r} - {base_r[32], base_r};
  assign win_ok  = anch_r && !woff[33] && (woff < 34'(LEVELS));
  assign win_idx = woff[LW-1:0];
  assign e_idx   = ent_rdata[LW-1:0];
  assign e_qty   = ent_rdata[LW+QTY_W-1:LW];
  assign e_sell  = ent_rdata[EW-1];
  assign e_newq  = e_qty - qty_r;
  assign kv      = key_rdata[KW-1];
  assign bsum    = base_r + {{(33-LW){1'b0}}, bbest_r};
  assign asum    = base_r + {{(33-LW){1'b0}}, abest_r};

  always_comb begin
    state_nxt = state_r;     clr_nxt = clr_r;       cmd_nxt = cmd_r;
    id_nxt = id_r;           nid_nxt = nid_r;       sell_nxt = sell_r;
    price_nxt = price_r;     qty_nxt = qty_r;       anch_nxt = anch_r;
    base_nxt = base_r;       live_nxt = live_r;     bcnt_nxt = bcnt_r;
    acnt_nxt = acnt_r;       bbest_nxt = bbest_r;   abest_nxt = abest_r;
    scan_nxt = scan_r;       spidx_nxt = spidx_r;   spend_nxt = 1'b0;
    hit_nxt = hit_r;         nhit_nxt = nhit_r;     free_nxt = free_r;
    hidx_nxt = hidx_r;       fidx_nxt = fidx_r;     status_nxt = status_r;
    lside_nxt = lside_r;     lsub_nxt = lsub_r;     addp_nxt = addp_r;
    aside_nxt = aside_r;     lidx_nxt = lidx_r;     lamt_nxt = lamt_r;
    rs_nxt = rs_r;           rs_pidx_nxt = rs_pidx_r;
    rs_more_nxt = rs_more_r; rs_pend_nxt = 1'b0;
    out_vld_nxt = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    key_we = 1'b0; key_waddr = hidx_r; key_wdata = '0;
    ent_we = 1'b0; ent_waddr = hidx_r; ent_wdata = '0;
    lvl_we = 1'b0; lvl_waddr = {lside_r, lidx_r}; lvl_wdata = '0;
    lvl_raddr = {sell_r, win_idx};
    nsum = '0;
    cnt_dec = '0;

    if (spend_r) begin
      if (kv && key_rdata[ID_W-1:0] == id_r && !hit_r) begin
        hit_nxt = 1'b1;
        hidx_nxt = spidx_r;
      end
      if (kv && key_rdata[ID_W-1:0] == nid_r) begin
        nhit_nxt = 1'b1;
      end
      if (!kv && !free_r) begin
        free_nxt = 1'b1;
        fidx_nxt = spidx_r;
      end
    end

    case (state_r)
      S_CLR: begin
        lvl_we = (clr_r < CLRW'(LDEPTH));
        lvl_waddr = clr_r[LAW-1:0];
        key_we = (clr_r < CLRW'(ORDERS));
        key_waddr = clr_r[OW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLRW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_tuser;
          id_nxt = in_tdata[31:0];
          nid_nxt = in_tdata[63:32];
          sell_nxt = in_tdata[64];
          price_nxt = in_tdata[96:65];
          qty_nxt = in_tdata[128:97];
          status_nxt = ST_OK;
          addp_nxt = 1'b0;
          if (in_tuser == CMD_ADD && in_tdata[128:97] != '0 && !anch_r) begin
            anch_nxt = 1'b1;
            base_nxt = {in_tdata[96], in_tdata[96:65]} - 33'(HALF);
          end
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        hit_nxt = 1'b0;
        nhit_nxt = 1'b0;
        free_nxt = 1'b0;
        scan_nxt = '0;
        case (cmd_r)
          CMD_ADD: begin
            if (qty_r == '0) begin
              status_nxt = ST_BAD_QTY;
              state_nxt = S_FIN;
            end else if (!win_ok) begin
              status_nxt = ST_WINDOW;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          CMD_CANCEL: begin
            state_nxt = S_SCAN;
          end
          CMD_REDUCE, CMD_EXECUTE, CMD_REPLACE: begin
            if (qty_r == '0) begin
              status_nxt = ST_BAD_QTY;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        spend_nxt = 1'b1;
        spidx_nxt = scan_r;
        if (scan_r == OW'(ORDERS - 1)) begin
          state_nxt = S_SDRN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_SDRN: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (cmd_r == CMD_ADD) begin
          if (hit_r) begin
            status_nxt = ST_DUP;
            state_nxt = S_FIN;
          end else if (live_r >= OCW'(ORDERS) || !free_r) begin
            status_nxt = ST_FULL;
            state_nxt = S_FIN;
          end else begin
            key_we = 1'b1;
            key_waddr = fidx_r;
            key_wdata = {1'b1, id_r};
            ent_we = 1'b1;
            ent_waddr = fidx_r;
            ent_wdata = {sell_r, qty_r, win_idx};
            live_nxt = live_r + 1'b1;
            lside_nxt = sell_r;
            lidx_nxt = win_idx;
            lamt_nxt = qty_r;
            lsub_nxt = 1'b0;
            state_nxt = S_LRD;
          end
        end else if (!hit_r) begin
          status_nxt = ST_UNKNOWN;
          state_nxt = S_FIN;
        end else if (cmd_r == CMD_REPLACE && nhit_r) begin
          status_nxt = ST_NEW_LIVE;
          state_nxt = S_FIN;
        end else if (cmd_r == CMD_REPLACE && !win_ok) begin
          status_nxt = ST_WINDOW;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ENT;
        end
      end
      S_ENT: begin
        lside_nxt = e_sell;
        lidx_nxt = e_idx;
        lsub_nxt = 1'b1;
        lamt_nxt = e_qty;
        state_nxt = S_LRD;
        case (cmd_r)
          CMD_CANCEL: begin
            key_we = 1'b1;
            live_nxt = live_r - 1'b1;
          end
          CMD_REPLACE: begin
            key_we = 1'b1;
            key_wdata = {1'b1, nid_r};
            ent_we = 1'b1;
            ent_wdata = {e_sell, qty_r, win_idx};
            addp_nxt = 1'b1;
            aside_nxt = e_sell;
          end
          default: begin
            lamt_nxt = qty_r;
            if (qty_r > e_qty) begin
              status_nxt = ST_EXCEEDS;
              state_nxt = S_FIN;
            end else if (e_newq == '0) begin
              key_we = 1'b1;
              live_nxt = live_r - 1'b1;
            end else begin
              ent_we = 1'b1;
              ent_wdata = {e_sell, e_newq, e_idx};
            end
          end
        endcase
      end
      S_LRD: begin
        lvl_raddr = {lside_r, lidx_r};
        state_nxt = S_LUPD;
      end
      S_LUPD: begin
        lvl_we = 1'b1;
        state_nxt = S_FIN;
        if (!lsub_r) begin
          nsum = lvl_rdata + {{(SUM_W-QTY_W){1'b0}}, lamt_r};
          if (lvl_rdata == '0) begin
            if (!lside_r) begin
              bcnt_nxt = bcnt_r + 1'b1;
              if (bcnt_r == '0 || lidx_r > bbest_r) bbest_nxt = lidx_r;
            end else begin
              acnt_nxt = acnt_r + 1'b1;
              if (acnt_r == '0 || lidx_r < abest_r) abest_nxt = lidx_r;
            end
          end
        end else begin
          nsum = lvl_rdata - {{(SUM_W-QTY_W){1'b0}}, lamt_r};
          if (addp_r) begin
            addp_nxt = 1'b0;
            lside_nxt = aside_r;
            lidx_nxt = win_idx;
            lamt_nxt = qty_r;
            lsub_nxt = 1'b0;
            state_nxt = S_LRD;
          end
          if (nsum == '0) begin
            if (!lside_r) begin
              cnt_dec = (bcnt_r != '0) ? bcnt_r - 1'b1 : bcnt_r;
              bcnt_nxt = cnt_dec;
              if (cnt_dec != '0 && lidx_r == bbest_r) begin
                rs_nxt = bbest_r - 1'b1;
                rs_more_nxt = (bbest_r != '0);
                state_nxt = S_RSC;
              end
            end else begin
              cnt_dec = (acnt_r != '0) ? acnt_r - 1'b1 : acnt_r;
              acnt_nxt = cnt_dec;
              if (cnt_dec != '0 && lidx_r == abest_r) begin
                rs_nxt = abest_r + 1'b1;
                rs_more_nxt = (abest_r != LW'(LEVELS - 1));
                state_nxt = S_RSC;
              end
            end
            if (state_nxt == S_RSC) begin
              addp_nxt = addp_r;
              lside_nxt = lside_r;
              lidx_nxt = lidx_r;
              lsub_nxt = lsub_r;
            end
          end
        end
        lvl_wdata = nsum;
      end
      S_RSC: begin
        lvl_raddr = {lside_r, rs_r};
        if (rs_pend_r && lvl_rdata != '0) begin
          if (!lside_r) bbest_nxt = rs_pidx_r;
          else abest_nxt = rs_pidx_r;
          rs_more_nxt = 1'b0;
        end else if (rs_more_r || rs_pend_r) begin
          rs_pend_nxt = rs_more_r;
          rs_pidx_nxt = rs_r;
          if (rs_more_r) begin
            if (!lside_r) begin
              rs_more_nxt = (rs_r != '0);
              rs_nxt = rs_r - 1'b1;
            end else begin
              rs_more_nxt = (rs_r != LW'(LEVELS - 1));
              rs_nxt = rs_r + 1'b1;
            end
          end
        end
        if ((rs_pend_r && lvl_rdata != '0) || (!rs_more_r && !rs_pend_r)) begin
          rs_pend_nxt = 1'b0;
          if (addp_r) begin
            addp_nxt = 1'b0;
            lside_nxt = aside_r;
            lidx_nxt = win_idx;
            lamt_nxt = qty_r;
            lsub_nxt = 1'b0;
            state_nxt = S_LRD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_data_nxt = {1'b0,
                          win_ok ? lvl_rdata : {SUM_W{1'b0}},
                          (acnt_r != '0) ? asum[31:0] : 32'd0,
                          acnt_r != '0,
                          (bcnt_r != '0) ? bsum[31:0] : 32'd0,
                          bcnt_r != '0,
                          status_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      anch_r <= 1'b0;
      base_r <= '0;
      live_r <= '0;
      bcnt_r <= '0;
      acnt_r <= '0;
      bbest_r <= '0;
      abest_r <= '0;
      spend_r <= 1'b0;
      rs_pend_r <= 1'b0;
      rs_more_r <= 1'b0;
      addp_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      anch_r <= anch_nxt;
      base_r <= base_nxt;
      live_r <= live_nxt;
      bcnt_r <= bcnt_nxt;
      acnt_r <= acnt_nxt;
      bbest_r <= bbest_nxt;
      abest_r <= abest_nxt;
      spend_r <= spend_nxt;
      rs_pend_r <= rs_pend_nxt;
      rs_more_r <= rs_more_nxt;
      addp_r <= addp_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    id_r <= id_nxt;
    nid_r <= nid_nxt;
    sell_r <= sell_nxt;
    price_r <= price_nxt;
    qty_r <= qty_nxt;
    scan_r <= scan_nxt;
    spidx_r <= spidx_nxt;
    hit_r <= hit_nxt;
    nhit_r <= nhit_nxt;
    free_r <= free_nxt;
    hidx_r <= hidx_nxt;
    fidx_r <= fidx_nxt;
    status_r <= status_nxt;
    lside_r <= lside_nxt;
    lsub_r <= lsub_nxt;
    aside_r <= aside_nxt;
    lidx_r <= lidx_nxt;
    lamt_r <= lamt_nxt;
    rs_r <= rs_nxt;
    rs_pidx_r <= rs_pidx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `PLOB_ALWAYS(a_live_bound, live_r <= OCW'(ORDERS))
  `PLOB_ALWAYS(a_clear_blocks, (state_r != S_CLR) || !in_tready)
  `PLOB_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `PLOB_ALWAYS(a_bid_best_range, (bcnt_r == '0) || (bbest_r <= LW'(LEVELS - 1)))
endmodule
